// File: rtl/core/ntuv_pkg.sv
// package: types and constants shared by the target aiming pipeline
package ntuv_pkg;

    localparam int CoordW  = 16;
    localparam int OffW    = 17;
    localparam int SqW     = 32;
    localparam int LenW    = 33;
    localparam int QBits   = 15;
    localparam int ProdW   = 48;
    localparam int RemW    = 64;
    localparam int FracW   = 28;
    localparam int CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y = 1'b1;

    typedef struct packed {
        logic signed [CoordW-1:0] target_a_x;
        logic signed [CoordW-1:0] target_a_y;
        logic signed [CoordW-1:0] target_b_x;
        logic signed [CoordW-1:0] target_b_y;
    } t_in;

    typedef struct packed {
        logic signed [CoordW-1:0] unit_x;
        logic signed [CoordW-1:0] unit_y;
        logic                     chosen_target;
    } t_out;

    typedef struct packed {
        logic [RemW-1:0]  rem;
        logic [ProdW-1:0] prod;
        logic [QBits-1:0] q;
        logic             neg;
    } t_lane;

    typedef struct packed {
        logic            pick_b;
        logic            zero;
        logic [LenW-1:0] len2;
        t_lane           lx;
        t_lane           ly;
    } t_ctx;

endpackage

// File: rtl/core/ntuv_iter.sv
// one quotient bit of the normalising search for both components
module ntuv_iter #(
    parameter int K = ntuv_pkg::QBits - 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  ntuv_pkg::t_ctx  i_ctx,
    output logic            o_valid,
    output ntuv_pkg::t_ctx  o_ctx
);

    localparam int RemW  = ntuv_pkg::RemW;
    localparam int ProdW = ntuv_pkg::ProdW;
    localparam int LenW  = ntuv_pkg::LenW;

    logic           r_valid;
    ntuv_pkg::t_ctx r_ctx;
    ntuv_pkg::t_ctx n_ctx;

    function automatic ntuv_pkg::t_lane f_step(ntuv_pkg::t_lane l, logic [LenW-1:0] len2);
        logic [RemW-1:0] term;
        ntuv_pkg::t_lane n;
        term = (RemW'(l.prod) << (K + 1)) + (RemW'(len2) << (2 * K));
        n = l;
        if (term <= l.rem) begin
            n.rem  = l.rem - term;
            n.prod = l.prod + (ProdW'(len2) << K);
            n.q[K] = 1'b1;
        end
        return n;
    endfunction

    always_comb begin
        n_ctx    = i_ctx;
        n_ctx.lx = f_step(i_ctx.lx, i_ctx.len2);
        n_ctx.ly = f_step(i_ctx.ly, i_ctx.len2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= n_ctx;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;

endmodule

// File: rtl/core/nearest_target_unit_vector.sv
// top level: picks the nearer of two targets and returns the Q1.14 unit vector toward it
// throughput: one item per cycle while the output is not stalled
// stages: three front stages, fifteen quotient-bit stages, one output stage
// a stall on a valid output freezes the whole pipeline, nothing is lost or repeated
// reset (synchronous, active low) clears all valid bits and sets both origin registers to zero
module nearest_target_unit_vector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  ntuv_pkg::t_in                       i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output ntuv_pkg::t_out                      o_data,
    input  logic                                i_cfg_we,
    input  logic [ntuv_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [ntuv_pkg::CoordW-1:0]         i_cfg_data
);

    localparam int OffW   = ntuv_pkg::OffW;
    localparam int SqW    = ntuv_pkg::SqW;
    localparam int LenW   = ntuv_pkg::LenW;
    localparam int QBits  = ntuv_pkg::QBits;
    localparam int CoordW = ntuv_pkg::CoordW;
    localparam int RemW   = ntuv_pkg::RemW;
    localparam int FracW  = ntuv_pkg::FracW;

    logic                     en;
    logic signed [CoordW-1:0] r_org_x;
    logic signed [CoordW-1:0] r_org_y;

    logic                     r1_valid;
    logic signed [OffW-1:0]   r1_off [4];
    logic                     r2_valid;
    logic [SqW-1:0]           r2_sq  [4];
    logic                     r2_neg [4];
    logic                     r3_valid;
    ntuv_pkg::t_ctx           r3_ctx;
    ntuv_pkg::t_ctx           n3_ctx;
    logic                     r_out_valid;
    ntuv_pkg::t_out           r_out;
    ntuv_pkg::t_out           n_out;

    logic                     w_valid [QBits+1];
    ntuv_pkg::t_ctx           w_ctx   [QBits+1];

    logic [LenW-1:0]          len_a;
    logic [LenW-1:0]          len_b;
    logic signed [2*OffW-1:0] prod [4];

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ntuv_pkg::CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                ntuv_pkg::CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= w_valid[QBits];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod[i] = r1_off[i] * r1_off[i];
        end
        len_a = LenW'(r2_sq[0]) + LenW'(r2_sq[1]);
        len_b = LenW'(r2_sq[2]) + LenW'(r2_sq[3]);
        n3_ctx        = '0;
        n3_ctx.pick_b = !(len_a < len_b);
        n3_ctx.len2   = n3_ctx.pick_b ? len_b : len_a;
        n3_ctx.zero   = (n3_ctx.len2 == '0);
        n3_ctx.lx.rem = RemW'(n3_ctx.pick_b ? r2_sq[2] : r2_sq[0]) << FracW;
        n3_ctx.ly.rem = RemW'(n3_ctx.pick_b ? r2_sq[3] : r2_sq[1]) << FracW;
        n3_ctx.lx.neg = n3_ctx.pick_b ? r2_neg[2] : r2_neg[0];
        n3_ctx.ly.neg = n3_ctx.pick_b ? r2_neg[3] : r2_neg[1];
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_off[0] <= OffW'(i_data.target_a_x) - OffW'(r_org_x);
            r1_off[1] <= OffW'(i_data.target_a_y) - OffW'(r_org_y);
            r1_off[2] <= OffW'(i_data.target_b_x) - OffW'(r_org_x);
            r1_off[3] <= OffW'(i_data.target_b_y) - OffW'(r_org_y);
            for (int i = 0; i < 4; i++) begin
                r2_sq[i]  <= prod[i][SqW-1:0];
                r2_neg[i] <= r1_off[i][OffW-1];
            end
            r3_ctx <= n3_ctx;
            r_out  <= n_out;
        end
    end

    assign w_valid[0] = r3_valid;
    assign w_ctx[0]   = r3_ctx;

    for (genvar g = 0; g < QBits; g++) begin : g_bit
        ntuv_iter #(
            .K (QBits - 1 - g)
        ) u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_ctx   (w_ctx[g]),
            .o_valid (w_valid[g+1]),
            .o_ctx   (w_ctx[g+1])
        );
    end

    always_comb begin
        logic [CoordW-1:0] qx;
        logic [CoordW-1:0] qy;
        qx = CoordW'(w_ctx[QBits].lx.q);
        qy = CoordW'(w_ctx[QBits].ly.q);
        n_out.unit_x        = w_ctx[QBits].lx.neg ? -qx : qx;
        n_out.unit_y        = w_ctx[QBits].ly.neg ? -qy : qy;
        n_out.chosen_target = w_ctx[QBits].pick_b;
        if (w_ctx[QBits].zero) begin
            n_out.unit_x = '0;
            n_out.unit_y = '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.unit_x <= 16'sd16384 && o_data.unit_x >= -16'sd16384
                  && o_data.unit_y <= 16'sd16384 && o_data.unit_y >= -16'sd16384))
        else $error("unit component out of range");

endmodule

// File: dv/tb_nearest_target_unit_vector.sv
// testbench: nearest target unit vector, predicted results compared item by item
`timescale 1ns / 100ps

module tb_nearest_target_unit_vector;

    localparam int LatencyCycles = 19;
    localparam int WatchdogLimit = 2000;
    localparam int HoldCycles    = 60;
    localparam int FifoDepth     = 4096;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    ntuv_pkg::t_in i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    ntuv_pkg::t_out o_data;
    logic i_cfg_we = 1'b0;
    logic [ntuv_pkg::CfgIdxW-1:0] i_cfg_idx = ntuv_pkg::CFG_ORIGIN_X;
    logic [ntuv_pkg::CoordW-1:0] i_cfg_data = '0;

    ntuv_pkg::t_out aim_fifo [FifoDepth];
    int aim_wr = 0;
    int aim_rd = 0;
    logic signed [ntuv_pkg::CoordW-1:0] org_x = '0;
    logic signed [ntuv_pkg::CoordW-1:0] org_y = '0;
    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_rx = 1'b0;

    nearest_target_unit_vector i_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic logic [15:0] unit_comp(longint d, longint len2);
        longint mag, lo, hi, mid, rhs;
        mag = (d < 0) ? -d : d;
        rhs = (mag * mag) << 28;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) >>> 1;
            if (mid * mid * len2 <= rhs) lo = mid;
            else hi = mid - 1;
        end
        if (d < 0) lo = -lo;
        return lo[15:0];
    endfunction

    function automatic ntuv_pkg::t_out aim_predict(ntuv_pkg::t_in t);
        longint ax, ay, bx, by, la, lb, dx, dy, l;
        ntuv_pkg::t_out r;
        ax = longint'(t.target_a_x) - longint'(org_x);
        ay = longint'(t.target_a_y) - longint'(org_y);
        bx = longint'(t.target_b_x) - longint'(org_x);
        by = longint'(t.target_b_y) - longint'(org_y);
        la = ax * ax + ay * ay;
        lb = bx * bx + by * by;
        r.chosen_target = !(la < lb);
        dx = r.chosen_target ? bx : ax;
        dy = r.chosen_target ? by : ay;
        l = r.chosen_target ? lb : la;
        if (l == 0) begin
            r.unit_x = '0;
            r.unit_y = '0;
        end else begin
            r.unit_x = unit_comp(dx, l);
            r.unit_y = unit_comp(dy, l);
        end
        return r;
    endfunction

    task automatic send_target_pair(ntuv_pkg::t_in t);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        aim_fifo[aim_wr] = aim_predict(t);
        aim_wr++;
    endtask

    task automatic send_pair(int ax, int ay, int bx, int by);
        ntuv_pkg::t_in t;
        t.target_a_x = ax[15:0];
        t.target_a_y = ay[15:0];
        t.target_b_x = bx[15:0];
        t.target_b_y = by[15:0];
        send_target_pair(t);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 20)) - 16'd10;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (aim_rd != aim_wr) @(posedge i_clk);
        repeat (LatencyCycles + 4) @(posedge i_clk);
    endtask

    task automatic set_origin(logic [15:0] x, logic [15:0] y);
        drain_pipeline();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= ntuv_pkg::CFG_ORIGIN_X;
        i_cfg_data <= x;
        @(posedge i_clk);
        i_cfg_idx <= ntuv_pkg::CFG_ORIGIN_Y;
        i_cfg_data <= y;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        org_x = x;
        org_y = y;
    endtask

    task automatic test_directed();
        send_pair(0, 0, 0, 0);
        send_pair(5, 0, 0, 5);
        send_pair(3, 4, 100, 100);
        send_pair(-3, -4, 3, 4);
        send_pair(0, -7, 100, 0);
        send_pair(32767, 32767, -32768, -32768);
        send_pair(-32768, 0, 0, 32767);
        send_pair(1, 1, 0, 0);
        send_pair(-1, 0, 1, 1);
        set_origin(16'h8000, 16'h8000);
        send_pair(32767, 32767, 32767, -32768);
        send_pair(-32768, -32768, 0, 0);
        set_origin(16'h7fff, 16'h8000);
        send_pair(-32768, 32767, -32768, -32768);
        send_pair(32767, -32768, 0, 0);
    endtask

    task automatic test_random(int n);
        ntuv_pkg::t_in t;
        for (int i = 0; i < n; i++) begin
            t.target_a_x = rand_coord();
            t.target_a_y = rand_coord();
            t.target_b_x = rand_coord();
            t.target_b_y = rand_coord();
            if ($urandom_range(0, 9) == 0) t.target_b_x = t.target_a_x;
            if ($urandom_range(0, 9) == 0) t.target_b_y = t.target_a_y;
            send_target_pair(t);
        end
    endtask

    task automatic test_backpressure();
        hold_rx = 1'b1;
        test_random(40);
    endtask

    initial begin : rx_side
        int gap;
        forever begin
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            gap = $urandom_range(0, 3);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (aim_rd == aim_wr) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %p", o_data);
            end else begin
                ntuv_pkg::t_out e;
                e = aim_fifo[aim_rd];
                aim_rd++;
                if (e.unit_x !== o_data.unit_x || e.unit_y !== o_data.unit_y
                        || e.chosen_target !== o_data.chosen_target) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", e, o_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_origin(16'h0000, 16'h0000);
        test_random(600);
        set_origin(16'($urandom), 16'($urandom));
        test_backpressure();
        test_random(600);
        set_origin(16'h0010, 16'hfff0);
        test_random(600);
        drain_pipeline();
        if (mismatches == 0 && aim_rd == aim_wr) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ntuv_pkg.sv
rtl/core/ntuv_iter.sv
rtl/core/nearest_target_unit_vector.sv
dv/tb_nearest_target_unit_vector.sv
